### rtl/core/ihm_pkg.sv
// Package with the field widths, operation and status codes and default sizes of the heap.
package ihm_pkg;

  localparam int unsigned FUNC_W = 2;
  localparam int unsigned ID_W   = 10;
  localparam int unsigned KEY_W  = 40;
  localparam int unsigned CNT_W  = 11;
  localparam int unsigned STAT_W = 2;

  localparam int unsigned ITEMS_DEF    = 1024;
  localparam int unsigned CAPACITY_DEF = 1024;
  localparam int unsigned KEY_BITS_DEF = 40;

  localparam logic [FUNC_W-1:0] FUNC_PUSH  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_POP   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY   = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL    = 2'd2;
  localparam logic [STAT_W-1:0] STAT_NOT_DEC = 2'd3;

endpackage

### rtl/core/ihm_ifs.sv
// Handshake interfaces for the heap operation channel and the result channel.
interface ihm_in_if import ihm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [ID_W-1:0]   item_id;
  logic [KEY_W-1:0]  item_key;

  modport source (output valid, output func, output item_id, output item_key, input ready);
  modport sink   (input valid, input func, input item_id, input item_key, output ready);
endinterface

interface ihm_out_if import ihm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ID_W-1:0]   min_item;
  logic [KEY_W-1:0]  min_key;
  logic [CNT_W-1:0]  count;
  logic              is_empty;
  logic [STAT_W-1:0] status;

  modport source (output valid, output min_item, output min_key, output count,
                  output is_empty, output status, input ready);
  modport sink   (input valid, input min_item, input min_key, input count,
                  input is_empty, input status, output ready);
endinterface

### rtl/core/indexed_min_heap_core.sv
// Indexed binary min-heap with decrease-key, run by a sequencer around one key comparator.
//
//   Channel  Direction  Payload                                   Handshake
//   in_i     sink       func, item_id, item_key                   valid and ready high
//   out_o    source     min_item, min_key, count, is_empty,       valid and ready high
//                       status
//
// One item is worked on at a time; ready is high only while the sequencer waits for work.
// A push climbs and a pop descends the heap one level at a time; each level needs a read of
// the heap, a compare and a write. Clear and pop on empty go straight to the result state.
// An item_id of ITEMS or more is first reduced modulo ITEMS by a reciprocal multiply and a subtract.
// After reset every entry of the position map is cleared before the first item is taken.
// A result waits in the output register; a new result is held back until it is taken.
module indexed_min_heap_core import ihm_pkg::*; #(
  parameter int unsigned ITEMS    = ITEMS_DEF,
  parameter int unsigned CAPACITY = CAPACITY_DEF,
  parameter int unsigned KEY_BITS = KEY_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ihm_in_if.sink    in_i,
  ihm_out_if.source out_o
);

  localparam int unsigned IW       = $clog2(ITEMS);
  localparam int unsigned PW       = $clog2(CAPACITY + 1);
  localparam int unsigned HAW      = $clog2(CAPACITY);
  localparam bit          NEED_RED = (ITEMS < (1 << ID_W));
  localparam int unsigned RCP_S    = 2 * ID_W;
  localparam logic [RCP_S-1:0]  RCP_M    = RCP_S'(((1 << RCP_S) + ITEMS - 1) / ITEMS);
  localparam logic [ID_W-1:0]   ITEMS_ID = ID_W'(ITEMS);
  localparam logic [ID_W:0]     ID_TOP   = NEED_RED ? (ID_W + 1)'(ITEMS) : (ID_W + 1)'(1 << ID_W);
  localparam logic [PW-1:0]     CAP_P    = PW'(CAPACITY);
  localparam logic [PW-1:0]     ONE_P    = PW'(1);
  localparam logic [IW-1:0]     INIT_END = IW'(ITEMS - 1);

  typedef struct packed {
    logic [IW-1:0]       item;
    logic [KEY_BITS-1:0] key;
  } entry_t;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_RED, S_RED_SUB, S_MAPRD, S_POSCHK, S_CHKQ, S_UP, S_UP_CMP,
    S_POP, S_POP_LAST, S_DN, S_DN_L, S_DN_R, S_DN_CMP, S_FIN
  } state_e;

  state_e              state_q;
  logic [IW-1:0]       init_q;
  logic [ID_W-1:0]     rem_q;
  logic [ID_W-1:0]     quo_q;
  entry_t              e_q;
  entry_t              left_q;
  entry_t              chosen_q;
  entry_t              root_q;
  logic [PW-1:0]       pos_q;
  logic [PW-1:0]       at_q;
  logic [PW-1:0]       cidx_q;
  logic [PW-1:0]       count_q;
  logic [STAT_W-1:0]   status_q;

  logic                out_valid_q;
  logic [ID_W-1:0]     out_item_q;
  logic [KEY_W-1:0]    out_key_q;
  logic [CNT_W-1:0]    out_count_q;
  logic                out_empty_q;
  logic [STAT_W-1:0]   out_status_q;

  entry_t              heap_mem [CAPACITY];
  logic [PW-1:0]       map_mem  [ITEMS];
  entry_t              heap_rd_q;
  logic [PW-1:0]       map_rd_q;

  logic                heap_we;
  logic [PW:0]         heap_wslot;
  entry_t              heap_wdata;
  logic [PW:0]         heap_rslot;
  logic                map_we;
  logic [IW-1:0]       map_waddr;
  logic [PW-1:0]       map_wdata;
  logic [IW-1:0]       map_raddr;

  logic [KEY_BITS-1:0] cmp_a;
  logic [KEY_BITS-1:0] cmp_b;
  logic                key_lt;
  logic [PW:0]         child_w;
  logic [PW:0]         cnt_w;
  logic                pos_valid;
  logic                out_free;
  logic [3*ID_W-1:0]   quo_prod;
  logic [2*ID_W-1:0]   quo_mul;

  assign child_w   = {at_q, 1'b0};
  assign cnt_w     = {1'b0, count_q};
  assign pos_valid = (map_rd_q != '0) && (map_rd_q <= count_q);
  assign out_free  = !out_valid_q || out_o.ready;
  assign key_lt    = cmp_a < cmp_b;
  assign quo_prod  = rem_q * RCP_M;
  assign quo_mul   = quo_q * ITEMS_ID;

  assign in_i.ready     = (state_q == S_IDLE);
  assign out_o.valid    = out_valid_q;
  assign out_o.min_item = out_item_q;
  assign out_o.min_key  = out_key_q;
  assign out_o.count    = out_count_q;
  assign out_o.is_empty = out_empty_q;
  assign out_o.status   = out_status_q;

  always_comb begin
    cmp_a = e_q.key;
    cmp_b = heap_rd_q.key;
    unique case (state_q)
      S_DN_R: begin
        cmp_a = heap_rd_q.key;
        cmp_b = left_q.key;
      end
      S_DN_CMP: begin
        cmp_b = chosen_q.key;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    heap_we    = 1'b0;
    heap_wslot = {1'b0, at_q};
    heap_wdata = e_q;
    heap_rslot = {1'b0, at_q};
    map_we     = 1'b0;
    map_waddr  = e_q.item;
    map_wdata  = at_q;
    map_raddr  = IW'(rem_q);
    unique case (state_q)
      S_INIT: begin
        map_we    = 1'b1;
        map_waddr = init_q;
        map_wdata = '0;
      end
      S_POSCHK: begin
        heap_rslot = {1'b0, map_rd_q};
      end
      S_UP: begin
        if (at_q == ONE_P) begin
          heap_we = 1'b1;
          map_we  = 1'b1;
        end else begin
          heap_rslot = {2'b00, at_q[PW-1:1]};
        end
      end
      S_UP_CMP: begin
        heap_we = 1'b1;
        map_we  = 1'b1;
        if (key_lt) begin
          heap_wdata = heap_rd_q;
          map_waddr  = heap_rd_q.item;
        end
      end
      S_POP: begin
        heap_rslot = cnt_w;
      end
      S_DN: begin
        if (child_w <= cnt_w) begin
          heap_rslot = child_w;
        end else begin
          heap_we = 1'b1;
          map_we  = 1'b1;
        end
      end
      S_DN_L: begin
        heap_rslot = child_w + 1'b1;
      end
      S_DN_CMP: begin
        heap_we = 1'b1;
        map_we  = 1'b1;
        if (!key_lt) begin
          heap_wdata = chosen_q;
          map_waddr  = chosen_q.item;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (heap_we) begin
      heap_mem[HAW'(heap_wslot - 1'b1)] <= heap_wdata;
    end
    heap_rd_q <= heap_mem[HAW'(heap_rslot - 1'b1)];
  end

  always_ff @(posedge clk_i) begin
    if (map_we) begin
      map_mem[map_waddr] <= map_wdata;
    end
    map_rd_q <= map_mem[map_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      init_q      <= '0;
      count_q     <= '0;
      status_q    <= STAT_OK;
      out_valid_q <= 1'b0;
    end else begin
      if (out_o.ready && (state_q != S_FIN)) begin
        out_valid_q <= 1'b0;
      end
      if (heap_we && (heap_wslot == {1'b0, ONE_P})) begin
        root_q <= heap_wdata;
      end
      unique case (state_q)
        S_INIT: begin
          init_q <= init_q + 1'b1;
          if (init_q == INIT_END) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_i.valid) begin
            e_q.key  <= KEY_BITS'(in_i.item_key);
            rem_q    <= in_i.item_id;
            status_q <= STAT_OK;
            unique case (in_i.func)
              FUNC_PUSH: begin
                if (NEED_RED && ({1'b0, in_i.item_id} >= ID_TOP)) begin
                  state_q <= S_RED;
                end else begin
                  state_q <= S_MAPRD;
                end
              end
              FUNC_POP: begin
                if (count_q == '0) begin
                  status_q <= STAT_EMPTY;
                  state_q  <= S_FIN;
                end else begin
                  state_q <= S_POP;
                end
              end
              FUNC_CLEAR: begin
                count_q <= '0;
                state_q <= S_FIN;
              end
              default: begin
                state_q <= S_FIN;
              end
            endcase
          end
        end
        S_RED: begin
          quo_q   <= quo_prod[3*ID_W-1:RCP_S];
          state_q <= S_RED_SUB;
        end
        S_RED_SUB: begin
          rem_q   <= rem_q - quo_mul[ID_W-1:0];
          state_q <= S_MAPRD;
        end
        S_MAPRD: begin
          e_q.item <= IW'(rem_q);
          state_q  <= S_POSCHK;
        end
        S_POSCHK: begin
          pos_q <= map_rd_q;
          if (pos_valid) begin
            state_q <= S_CHKQ;
          end else if (count_q >= CAP_P) begin
            status_q <= STAT_FULL;
            state_q  <= S_FIN;
          end else begin
            count_q <= count_q + 1'b1;
            at_q    <= count_q + 1'b1;
            state_q <= S_UP;
          end
        end
        S_CHKQ: begin
          if (heap_rd_q.item == e_q.item) begin
            if (key_lt) begin
              at_q    <= pos_q;
              state_q <= S_UP;
            end else begin
              status_q <= STAT_NOT_DEC;
              state_q  <= S_FIN;
            end
          end else if (count_q >= CAP_P) begin
            status_q <= STAT_FULL;
            state_q  <= S_FIN;
          end else begin
            count_q <= count_q + 1'b1;
            at_q    <= count_q + 1'b1;
            state_q <= S_UP;
          end
        end
        S_UP: begin
          if (at_q == ONE_P) begin
            state_q <= S_FIN;
          end else begin
            state_q <= S_UP_CMP;
          end
        end
        S_UP_CMP: begin
          if (key_lt) begin
            at_q    <= at_q >> 1;
            state_q <= S_UP;
          end else begin
            state_q <= S_FIN;
          end
        end
        S_POP: begin
          state_q <= S_POP_LAST;
        end
        S_POP_LAST: begin
          e_q     <= heap_rd_q;
          count_q <= count_q - 1'b1;
          at_q    <= ONE_P;
          if (count_q == ONE_P) begin
            state_q <= S_FIN;
          end else begin
            state_q <= S_DN;
          end
        end
        S_DN: begin
          if (child_w <= cnt_w) begin
            state_q <= S_DN_L;
          end else begin
            state_q <= S_FIN;
          end
        end
        S_DN_L: begin
          left_q <= heap_rd_q;
          if (child_w < cnt_w) begin
            state_q <= S_DN_R;
          end else begin
            chosen_q <= heap_rd_q;
            cidx_q   <= PW'(child_w);
            state_q  <= S_DN_CMP;
          end
        end
        S_DN_R: begin
          if (key_lt) begin
            chosen_q <= heap_rd_q;
            cidx_q   <= PW'(child_w + 1'b1);
          end else begin
            chosen_q <= left_q;
            cidx_q   <= PW'(child_w);
          end
          state_q <= S_DN_CMP;
        end
        S_DN_CMP: begin
          if (key_lt) begin
            state_q <= S_FIN;
          end else begin
            at_q    <= cidx_q;
            state_q <= S_DN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            out_valid_q  <= 1'b1;
            out_count_q  <= CNT_W'(count_q);
            out_status_q <= status_q;
            if (count_q != '0) begin
              out_item_q  <= ID_W'(root_q.item);
              out_key_q   <= KEY_W'(root_q.key);
              out_empty_q <= 1'b0;
            end else begin
              out_item_q  <= '0;
              out_key_q   <= '0;
              out_empty_q <= 1'b1;
            end
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### tb/tb_top.sv
// Self-checking testbench for indexed_min_heap_core with its own heap model and random traffic.
module tb_top;
  import ihm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam int unsigned SLOTS = CAPACITY_DEF;
  localparam int unsigned IDS = ITEMS_DEF;

  typedef struct packed {
    logic [ID_W-1:0]   min_item;
    logic [KEY_W-1:0]  min_key;
    logic [CNT_W-1:0]  count;
    logic              is_empty;
    logic [STAT_W-1:0] status;
  } heap_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  ihm_in_if  op_if ();
  ihm_out_if res_if ();

  indexed_min_heap_core dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (op_if),
    .out_o (res_if)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  logic [ID_W-1:0]  hp_item [0:SLOTS];
  logic [KEY_W-1:0] hp_key  [0:SLOTS];
  int unsigned      slot_of [IDS];
  int unsigned      heap_size;
  int unsigned      deepest;

  heap_result_t expected_results [$];
  int unsigned  mismatches;
  int unsigned  ops_sent;
  int unsigned  results_checked;
  int unsigned  status_seen [4];

  bit          src_gaps_on = 1'b1;
  bit          sink_stalls_on = 1'b1;
  int unsigned hold_len = 0;

  function automatic void heap_raise(int unsigned at, logic [ID_W-1:0] id,
                                     logic [KEY_W-1:0] key);
    while (at > 1 && hp_key[at / 2] > key) begin
      hp_item[at] = hp_item[at / 2];
      hp_key[at] = hp_key[at / 2];
      slot_of[hp_item[at]] = at;
      at = at / 2;
    end
    hp_item[at] = id;
    hp_key[at] = key;
    slot_of[id] = at;
  endfunction

  function automatic void heap_lower(logic [ID_W-1:0] id, logic [KEY_W-1:0] key);
    int unsigned at;
    int unsigned c;
    bit          settled;
    at = 1;
    settled = 1'b0;
    while (!settled && 2 * at <= heap_size) begin
      c = 2 * at;
      if (c + 1 <= heap_size && hp_key[c + 1] < hp_key[c]) c = c + 1;
      if (key < hp_key[c]) begin
        settled = 1'b1;
      end else begin
        hp_item[at] = hp_item[c];
        hp_key[at] = hp_key[c];
        slot_of[hp_item[at]] = at;
        at = c;
      end
    end
    hp_item[at] = id;
    hp_key[at] = key;
    slot_of[id] = at;
  endfunction

  function automatic heap_result_t heap_apply(logic [FUNC_W-1:0] op, logic [ID_W-1:0] id,
                                              logic [KEY_W-1:0] key);
    heap_result_t r;
    int unsigned  pos;
    logic [ID_W-1:0]  last_id;
    logic [KEY_W-1:0] last_key;
    r = '0;
    r.status = STAT_OK;
    case (op)
      FUNC_PUSH: begin
        pos = slot_of[id % IDS];
        if (pos != 0 && pos <= heap_size) begin
          if (key < hp_key[pos]) heap_raise(pos, id, key);
          else r.status = STAT_NOT_DEC;
        end else if (heap_size >= SLOTS) begin
          r.status = STAT_FULL;
        end else begin
          heap_size++;
          heap_raise(heap_size, id, key);
        end
      end
      FUNC_POP: begin
        if (heap_size == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          last_id = hp_item[heap_size];
          last_key = hp_key[heap_size];
          slot_of[hp_item[1]] = 0;
          heap_size--;
          if (heap_size > 0) heap_lower(last_id, last_key);
        end
      end
      FUNC_CLEAR: begin
        foreach (slot_of[i]) slot_of[i] = 0;
        heap_size = 0;
      end
      default: ;
    endcase
    if (heap_size > 0) begin
      r.min_item = hp_item[1];
      r.min_key = hp_key[1];
      r.is_empty = 1'b0;
    end else begin
      r.is_empty = 1'b1;
    end
    r.count = heap_size[CNT_W-1:0];
    if (heap_size > deepest) deepest = heap_size;
    status_seen[r.status]++;
    return r;
  endfunction

  function automatic int unsigned pick_gap(bit at_least_one);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!at_least_one && r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(15, 50);
  endfunction

  function automatic logic [KEY_W-1:0] rand_key();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    return w[KEY_W-1:0];
  endfunction

  function automatic logic [KEY_W-1:0] pick_key();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 5) return rand_key();
    if (r < 8) return KEY_W'($urandom_range(0, 15));
    if (r == 8) return '0;
    return '1;
  endfunction

  function automatic logic [ID_W-1:0] pick_id();
    if ($urandom_range(0, 9) < 6) return ID_W'($urandom_range(0, 63));
    return ID_W'($urandom_range(0, IDS - 1));
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin : result_check
    heap_result_t want;
    if (rst_ni && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
      if (expected_results.size() == 0) begin
        $error("result with no operation pending: item 0x%0h key 0x%0h count %0d",
               res_if.min_item, res_if.min_key, res_if.count);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        check_field("min_item", 64'(want.min_item), 64'(res_if.min_item));
        check_field("min_key", 64'(want.min_key), 64'(res_if.min_key));
        check_field("count", 64'(want.count), 64'(res_if.count));
        check_field("is_empty", 64'(want.is_empty), 64'(res_if.is_empty));
        check_field("status", 64'(want.status), 64'(res_if.status));
        results_checked++;
      end
    end
  end

  initial begin : result_sink
    int unsigned stall_left;
    stall_left = 0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_len != 0) begin
        stall_left = hold_len;
        hold_len = 0;
      end else if (stall_left == 0 && sink_stalls_on && $urandom_range(0, 3) == 0) begin
        stall_left = pick_gap(1'b1);
      end
      if (stall_left != 0) begin
        res_if.ready <= 1'b0;
        stall_left--;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  task automatic send_op(logic [FUNC_W-1:0] op, logic [ID_W-1:0] id, logic [KEY_W-1:0] key);
    int unsigned gap;
    op_if.valid <= 1'b1;
    op_if.func <= op;
    op_if.item_id <= id;
    op_if.item_key <= key;
    @(posedge clk_i);
    while (op_if.ready !== 1'b1) @(posedge clk_i);
    expected_results.insert(expected_results.size(), heap_apply(op, id, key));
    ops_sent++;
    gap = src_gaps_on ? pick_gap(1'b0) : 0;
    if (gap != 0) begin
      op_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_all_results();
    op_if.valid <= 1'b0;
    do @(posedge clk_i); while (expected_results.size() != 0);
  endtask

  task automatic test_directed_ops();
    send_op(FUNC_POP, 10'd0, '0);
    send_op(FUNC_UNUSED, 10'd3, '1);
    send_op(FUNC_CLEAR, 10'd0, '0);
    send_op(FUNC_PUSH, 10'd1023, '1);
    send_op(FUNC_PUSH, 10'd0, '0);
    send_op(FUNC_PUSH, 10'd7, 40'd100);
    send_op(FUNC_PUSH, 10'd8, 40'd100);
    send_op(FUNC_PUSH, 10'd9, 40'd100);
    send_op(FUNC_PUSH, 10'd7, 40'd100);
    send_op(FUNC_PUSH, 10'd1023, '1);
    send_op(FUNC_PUSH, 10'd1023, 40'd50);
    send_op(FUNC_UNUSED, 10'd1023, '0);
    repeat (6) send_op(FUNC_POP, 10'd0, '0);
    send_op(FUNC_PUSH, 10'd0, 40'd5);
    send_op(FUNC_PUSH, 10'd1, 40'd3);
    send_op(FUNC_CLEAR, 10'd1, '0);
    send_op(FUNC_PUSH, 10'd0, 40'd9);
    send_op(FUNC_POP, 10'd0, '0);
    send_op(FUNC_POP, 10'd0, '0);
    wait_all_results();
  endtask

  task automatic test_output_backpressure();
    hold_len = 300;
    for (int i = 0; i < 12; i++) send_op(FUNC_PUSH, pick_id(), pick_key());
    wait_all_results();
    send_op(FUNC_POP, 10'd0, '0);
    wait_all_results();
  endtask

  task automatic test_random_traffic(int unsigned n);
    int unsigned r;
    int unsigned s;
    int unsigned push_weight;
    logic [KEY_W-1:0] k;
    for (int unsigned i = 0; i < n; i++) begin
      if (i % 64 == 0) begin
        src_gaps_on = $urandom_range(0, 2) != 0;
        sink_stalls_on = $urandom_range(0, 2) != 0;
      end
      push_weight = heap_size > 150 ? 35 : 55;
      r = $urandom_range(0, 99);
      if (r < push_weight) begin
        if (heap_size > 0 && $urandom_range(0, 3) == 0) begin
          s = $urandom_range(1, heap_size);
          if (hp_key[s] != 0 && $urandom_range(0, 4) != 0) k = rand_key() % hp_key[s];
          else k = hp_key[s] + KEY_W'($urandom_range(0, 3));
          send_op(FUNC_PUSH, hp_item[s], k);
        end else begin
          send_op(FUNC_PUSH, pick_id(), pick_key());
        end
      end else if (r < 96) begin
        send_op(FUNC_POP, pick_id(), pick_key());
      end else if (r < 98) begin
        send_op(FUNC_CLEAR, pick_id(), pick_key());
      end else begin
        send_op(FUNC_UNUSED, pick_id(), pick_key());
      end
    end
    wait_all_results();
  endtask

  initial begin
    #3_000_000;
    $display("indexed_min_heap_core regression: fail");
    $finish;
  end

  initial begin
    foreach (slot_of[i]) slot_of[i] = 0;
    foreach (hp_key[i]) begin
      hp_key[i] = '0;
      hp_item[i] = '0;
    end
    heap_size = 0;
    deepest = 0;
    op_if.valid <= 1'b0;
    op_if.func <= FUNC_PUSH;
    op_if.item_id <= '0;
    op_if.item_key <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_directed_ops();
    test_output_backpressure();
    test_random_traffic(900);
    test_output_backpressure();

    repeat (200) @(posedge clk_i);
    if (expected_results.size() != 0) begin
      $error("%0d results never arrived", expected_results.size());
      mismatches++;
    end
    $display("Sent %0d operations and checked %0d results; the heap grew to %0d entries.",
             ops_sent, results_checked, deepest);
    $display("Status codes seen: ok %0d, pop on empty %0d, full %0d, key not lowered %0d.",
             status_seen[STAT_OK], status_seen[STAT_EMPTY], status_seen[STAT_FULL],
             status_seen[STAT_NOT_DEC]);
    if (mismatches == 0) begin
      $display("indexed_min_heap_core regression: pass");
    end else begin
      $display("indexed_min_heap_core regression: fail");
    end
    $finish;
  end

endmodule

### indexed_min_heap_core.f
rtl/core/ihm_pkg.sv
rtl/core/ihm_ifs.sv
rtl/core/indexed_min_heap_core.sv
tb/tb_top.sv
